// ===== rtl/deq_pkg.sv =====
// shared types, codes and defaults for the double-ended queue core
// no dependencies; imported by deq_cell, deq_chain and double_ended_queue_core
package deq_pkg;

    localparam int CAPACITY_DEFAULT = 16;
    localparam int WORD_W           = 32;
    localparam int ACTION_W         = 3;
    localparam int STATUS_W         = 2;

    typedef logic signed [WORD_W-1:0] word_t;

    // transaction codes on the action port
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_PEEK_FRONT = 3'd4,
        ACT_PEEK_BACK  = 3'd5
    } action_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // what one chain does in a cycle
    typedef enum logic [1:0] {
        CH_HOLD       = 2'd0,
        CH_PUSH_HEAD  = 2'd1,
        CH_POP_HEAD   = 2'd2,
        CH_WRITE_TAIL = 2'd3
    } chain_op_t;

    // what one cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_SHIFT_UP   = 2'd1,
        CELL_SHIFT_DOWN = 2'd2,
        CELL_LOAD       = 2'd3
    } cell_mode_t;

    // command to one chain: operation plus the word to insert
    typedef struct packed {
        chain_op_t op;
        word_t     word;
    } chain_cmd_t;

endpackage

// ===== rtl/deq_cell.sv =====
// one storage cell of the deque chain: holds a word, takes it from a neighbor or a load
// depends on deq_pkg
module deq_cell (
    input  logic               clk,
    input  deq_pkg::cell_mode_t mode,
    input  deq_pkg::word_t     lower_word,
    input  deq_pkg::word_t     upper_word,
    input  deq_pkg::word_t     load_word,
    output deq_pkg::word_t     word
);
    import deq_pkg::*;

    word_t word_reg;
    word_t word_next;

    // select the source of the stored word
    always_comb
    begin
        case (mode)
            CELL_SHIFT_UP:   word_next = lower_word;
            CELL_SHIFT_DOWN: word_next = upper_word;
            CELL_LOAD:       word_next = load_word;
            default:         word_next = word_reg;
        endcase
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== rtl/deq_chain.sv =====
// row of deq_cell instances: cell 0 is the head, words are packed from the head
// depends on deq_pkg and deq_cell
module deq_chain #(
    parameter int DEPTH = deq_pkg::CAPACITY_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic               clk,
    input  deq_pkg::chain_cmd_t cmd,
    input  logic [CNT_W-1:0]   tail,
    output deq_pkg::word_t     head_word
);
    import deq_pkg::*;

    word_t cell_word [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            cell_mode_t mode;
            word_t      lower_word;
            word_t      upper_word;

            // neighbor links: head takes the new word, last cell keeps its own
            if (i == 0)
            begin : g_head
                assign lower_word = cmd.word;
            end
            else
            begin : g_mid_lo
                assign lower_word = cell_word[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign upper_word = cell_word[i];
            end
            else
            begin : g_mid_hi
                assign upper_word = cell_word[i+1];
            end

            // per-cell mode from the chain operation
            always_comb
            begin
                case (cmd.op)
                    CH_PUSH_HEAD:  mode = CELL_SHIFT_UP;
                    CH_POP_HEAD:   mode = CELL_SHIFT_DOWN;
                    CH_WRITE_TAIL: mode = (tail == CNT_W'(i)) ? CELL_LOAD : CELL_HOLD;
                    default:       mode = CELL_HOLD;
                endcase
            end

            deq_cell u_cell (
                .clk        (clk),
                .mode       (mode),
                .lower_word (lower_word),
                .upper_word (upper_word),
                .load_word  (cmd.word),
                .word       (cell_word[i])
            );
        end
    endgenerate

    assign head_word = cell_word[0];

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// top level of the bounded double-ended queue of signed 32-bit words
// depends on deq_pkg and deq_chain (which uses deq_cell)
//
// The core takes one transaction per clock: busy is never raised, and the result of a
// transaction accepted at a clock edge appears on read_word, status and is_empty with
// done high for exactly one cycle right after that edge; results cannot be held off, so
// the receiver must take each one when done is high. Storage is two chains of CAPACITY
// cells: one keeps the words packed from the front, the other packed from the back, so
// every pop and peek reads a fixed head cell and every push is a one-step shift or a
// single cell write. A push into a full deque returns status full and changes nothing;
// a pop or peek on an empty deque returns status empty and changes nothing. Codes 6 and 7
// are no-ops with status ok. read_word is zero for pushes, errors and no-ops.
module double_ended_queue_core #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [deq_pkg::ACTION_W-1:0]     action,
    input  deq_pkg::word_t                   value,
    output logic                             done,
    output deq_pkg::word_t                   read_word,
    output logic [deq_pkg::STATUS_W-1:0]     status,
    output logic                             is_empty
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             done_next;
    word_t            read_word_reg;
    word_t            read_word_next;
    status_t          status_reg;
    status_t          status_next;
    logic             is_empty_reg;
    logic             is_empty_next;

    chain_cmd_t       front_cmd;
    chain_cmd_t       back_cmd;
    word_t            front_head;
    word_t            back_head;
    logic             accept;
    logic             full;
    logic             empty;

    // busy is never raised: the core accepts a transaction whenever start is high
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);

    // words packed from the front: cell 0 holds the front word
    deq_chain #(
        .DEPTH (CAPACITY),
        .CNT_W (CNT_W)
    ) u_front_chain (
        .clk       (clk),
        .cmd       (front_cmd),
        .tail      (count_reg),
        .head_word (front_head)
    );

    // words packed from the back: cell 0 holds the back word
    deq_chain #(
        .DEPTH (CAPACITY),
        .CNT_W (CNT_W)
    ) u_back_chain (
        .clk       (clk),
        .cmd       (back_cmd),
        .tail      (count_reg),
        .head_word (back_head)
    );

    // decode the transaction into chain commands, count update and result
    always_comb
    begin
        front_cmd.op   = CH_HOLD;
        front_cmd.word = value;
        back_cmd.op    = CH_HOLD;
        back_cmd.word  = value;
        count_next     = count_reg;
        read_word_next = '0;
        status_next    = ST_OK;

        if (accept)
        begin
            case (action)
                ACT_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        front_cmd.op = CH_PUSH_HEAD;
                        back_cmd.op  = CH_WRITE_TAIL;
                        count_next   = count_reg + CNT_W'(1);
                    end
                end
                ACT_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        front_cmd.op = CH_WRITE_TAIL;
                        back_cmd.op  = CH_PUSH_HEAD;
                        count_next   = count_reg + CNT_W'(1);
                    end
                end
                ACT_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        read_word_next = front_head;
                        front_cmd.op   = CH_POP_HEAD;
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                ACT_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        read_word_next = back_head;
                        back_cmd.op    = CH_POP_HEAD;
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                ACT_PEEK_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        read_word_next = front_head;
                    end
                end
                ACT_PEEK_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        read_word_next = back_head;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end

        done_next     = accept;
        is_empty_next = (count_next == '0);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // result payload, captured with each transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_word_reg <= read_word_next;
            status_reg    <= status_next;
            is_empty_reg  <= is_empty_next;
        end
    end

    assign done      = done_reg;
    assign read_word = read_word_reg;
    assign status    = status_reg;
    assign is_empty  = is_empty_reg;

endmodule
